>>> rtl/bhp_pkg.sv
// ----------------------------------------------------------------------------
// BMP header parser package
// Beat types, status codes and the byte positions of the header fields.
// ----------------------------------------------------------------------------
package bhp_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIG   = 3'd1,
        ST_RESERVED  = 3'd2,
        ST_HDR_SIZE  = 3'd3,
        ST_PLANES    = 3'd4,
        ST_BIT_COUNT = 3'd5,
        ST_DIMS      = 3'd6
    } t_status;

    // One input beat: a file byte and its start flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        t_status            status;
        logic signed [31:0] image_width;
        logic        [30:0] image_height;
        logic        [3:0]  channel_bits;
        logic        [1:0]  channel_count;
        logic        [34:0] horiz_dpi;
        logic        [34:0] vert_dpi;
    } t_out_beat;

    // Signature bytes.
    localparam logic [7:0] SIG_FIRST  = 8'h42;
    localparam logic [7:0] SIG_SECOND = 8'h4D;

    // Header sizes.
    localparam logic [31:0] HDR_CORE  = 32'd12;
    localparam logic [31:0] HDR_INFO  = 32'd40;
    localparam logic [31:0] HDR_INFO2 = 32'd64;
    localparam logic [31:0] HDR_INFO4 = 32'd108;
    localparam logic [31:0] HDR_INFO5 = 32'd124;
    localparam logic [8:0]  FILE_HDR_BYTES = 9'd14;

    // Bit counts.
    localparam logic [15:0] BC_ONE  = 16'd1;
    localparam logic [15:0] BC_FOUR = 16'd4;
    localparam logic [15:0] BC_EIGHT = 16'd8;
    localparam logic [15:0] BC_FULL = 16'd24;

    // Resolution: meters to inches in Q.16 for a Q.8 result, and the fixed core header value.
    localparam logic [10:0] DPI_MUL     = 11'd1665;
    localparam logic [34:0] CORE_DPI_Q8 = 35'd18432;

    // Byte positions at which a field ends.
    localparam logic [7:0] POS_SIG0       = 8'd0;
    localparam logic [7:0] POS_SIG1       = 8'd1;
    localparam logic [7:0] POS_RSVD_END   = 8'd9;
    localparam logic [7:0] POS_OFFSET_END = 8'd13;
    localparam logic [7:0] POS_HSIZE_END  = 8'd17;
    localparam logic [7:0] POS_DIB_FIELDS = 8'd18;
    localparam logic [7:0] POS_LAST       = 8'd255;

    localparam logic [7:0] CORE_POS_WIDTH  = 8'd19;
    localparam logic [7:0] CORE_POS_HEIGHT = 8'd21;
    localparam logic [7:0] CORE_POS_PLANES = 8'd23;
    localparam logic [7:0] CORE_POS_BITS   = 8'd25;

    localparam logic [7:0] INFO_POS_WIDTH  = 8'd21;
    localparam logic [7:0] INFO_POS_HEIGHT = 8'd25;
    localparam logic [7:0] INFO_POS_PLANES = 8'd27;
    localparam logic [7:0] INFO_POS_BITS   = 8'd29;
    localparam logic [7:0] INFO_POS_XPELS  = 8'd41;
    localparam logic [7:0] INFO_POS_YPELS  = 8'd45;

endpackage

>>> rtl/bmp_header_parser_top.sv
// ----------------------------------------------------------------------------
// BMP header parser
// Walks the file and DIB headers of a BMP stream and reports the image format.
// ----------------------------------------------------------------------------
// The parser takes one file byte per cycle, every cycle while the input is not
// stalled, with no gaps needed; a byte with start_req set begins a new file at
// byte 0. Each byte updates the header state in the cycle it is accepted, and a
// file gives one result beat, at the first error or at the last DIB header byte,
// which is registered in the output buffer. Quantities needed only at the end
// of the header (resolution products, absolute height, palette check) are kept
// in registers that follow the stored fields, so the byte path holds only
// compares and selection. Input stalls only when a result is held downstream
// and a second one already sits in the skid entry. Bytes after a result, or
// before any start, are dropped without a result.
// ----------------------------------------------------------------------------
module bmp_header_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bhp_pkg::t_in_beat  i_in_beat,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output bhp_pkg::t_out_beat o_out_beat,
    input  logic               i_out_stall
);
    import bhp_pkg::*;

    // Parse state.
    logic [7:0]  r_pos, n_pos;
    logic        r_finished, n_finished;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_data_offset, n_data_offset;
    logic [7:0]  r_hdr, n_hdr;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [4:0]  r_bit_count, n_bit_count;
    logic [31:0] r_x_pels, n_x_pels;
    logic [31:0] r_y_pels, n_y_pels;

    // Values derived from the stored fields, registered behind them.
    logic [34:0] r_hdpi, r_vdpi;
    logic [30:0] r_height_abs;
    logic        r_pal_ok;

    logic        w_buf_full;
    logic        w_act;
    logic        w_start;
    logic [7:0]  w_pos;
    logic [31:0] w_fs;
    logic [15:0] w_w16;
    logic        w_core;
    logic        w_emit;
    t_status     w_status;
    t_out_beat   w_res;
    logic [4:0]  w_fin_bits;
    logic [42:0] w_hprod, w_vprod;
    logic [32:0] w_pal_need;
    logic [31:0] w_neg_height;

    function automatic logic size_known(input logic [31:0] s);
        return (s == HDR_CORE) || (s == HDR_INFO) || (s == HDR_INFO2) ||
               (s == HDR_INFO4) || (s == HDR_INFO5);
    endfunction

    function automatic logic bits_ok(input logic [15:0] bc);
        return (bc == BC_ONE) || (bc == BC_FOUR) || (bc == BC_EIGHT) ||
               (bc == BC_FULL);
    endfunction

    assign o_in_stall = w_buf_full;
    assign w_start    = i_in_beat.start_req;
    assign w_act      = i_in_valid & ~w_buf_full & (w_start | ~r_finished);
    assign w_pos      = w_start ? POS_SIG0 : r_pos;
    assign w_fs       = {i_in_beat.data_byte, (w_start ? 24'd0 : r_shift[31:8])};
    assign w_w16      = w_fs[31:16];
    assign w_core     = ({24'd0, r_hdr} == HDR_CORE);

    // Per-byte field capture and checks.
    always_comb begin
        n_pos         = r_pos;
        n_finished    = r_finished;
        n_shift       = r_shift;
        n_data_offset = r_data_offset;
        n_hdr         = r_hdr;
        n_width       = r_width;
        n_height      = r_height;
        n_bit_count   = r_bit_count;
        n_x_pels      = r_x_pels;
        n_y_pels      = r_y_pels;
        w_emit        = 1'b0;
        w_status      = ST_OK;
        w_fin_bits    = r_bit_count;

        if (w_act) begin
            if (w_start) begin
                n_data_offset = '0;
                n_hdr         = '0;
                n_width       = '0;
                n_height      = '0;
                n_bit_count   = '0;
                n_x_pels      = '0;
                n_y_pels      = '0;
            end
            n_shift = w_fs;

            if (w_pos == POS_SIG0 || w_pos == POS_SIG1) begin
                if (i_in_beat.data_byte != ((w_pos == POS_SIG0) ? SIG_FIRST : SIG_SECOND))
                begin
                    w_status = ST_BAD_SIG;
                    w_emit   = 1'b1;
                end
            end else if (w_pos == POS_RSVD_END) begin
                if (w_fs != 32'd0) begin
                    w_status = ST_RESERVED;
                    w_emit   = 1'b1;
                end
            end else if (w_pos == POS_OFFSET_END) begin
                n_data_offset = w_fs;
            end else if (w_pos == POS_HSIZE_END) begin
                n_hdr = w_fs[7:0];
                if (!size_known(w_fs)) begin
                    w_status = ST_HDR_SIZE;
                    w_emit   = 1'b1;
                end
            end else if (w_pos >= POS_DIB_FIELDS) begin
                if (w_core) begin
                    // Core header: 16-bit fields, result at the bit count.
                    if (w_pos == CORE_POS_WIDTH) begin
                        n_width = {16'd0, w_w16};
                    end else if (w_pos == CORE_POS_HEIGHT) begin
                        n_height = {16'd0, w_w16};
                    end else if (w_pos == CORE_POS_PLANES) begin
                        if (w_w16 != 16'd1) begin
                            w_status = ST_PLANES;
                            w_emit   = 1'b1;
                        end
                    end else if (w_pos == CORE_POS_BITS) begin
                        n_bit_count = w_w16[4:0];
                        w_fin_bits  = w_w16[4:0];
                        if (!bits_ok(w_w16)) begin
                            w_status = ST_BIT_COUNT;
                        end
                        w_emit = 1'b1;
                    end
                end else begin
                    // Info headers: 32-bit fields, result at the last byte.
                    if (w_pos == INFO_POS_WIDTH) begin
                        n_width = w_fs;
                    end else if (w_pos == INFO_POS_HEIGHT) begin
                        n_height = w_fs;
                    end else if (w_pos == INFO_POS_PLANES) begin
                        if (w_w16 != 16'd1) begin
                            w_status = ST_PLANES;
                            w_emit   = 1'b1;
                        end
                    end else if (w_pos == INFO_POS_BITS) begin
                        n_bit_count = w_w16[4:0];
                        if (!bits_ok(w_w16)) begin
                            w_status = ST_BIT_COUNT;
                            w_emit   = 1'b1;
                        end
                    end else if (w_pos == INFO_POS_XPELS) begin
                        n_x_pels = w_fs;
                    end else if (w_pos == INFO_POS_YPELS) begin
                        n_y_pels = w_fs;
                    end
                    if (!w_emit && (w_pos == r_hdr + POS_OFFSET_END)) begin
                        w_emit = 1'b1;
                    end
                end

                // Final checks on dimensions and palette size.
                if (w_emit && w_status == ST_OK) begin
                    if (r_width == 32'd0 || r_height == 32'd0 ||
                        (({27'd0, w_fin_bits} != 32'(BC_FULL)) && !r_pal_ok)) begin
                        w_status = ST_DIMS;
                    end
                end
            end

            if (w_pos != POS_LAST) begin
                n_pos = w_pos + 8'd1;
            end else begin
                n_pos = w_pos;
            end
            n_finished = w_emit;
        end
    end

    // Result beat; all fields but status are zero on an error.
    always_comb begin
        w_res = '0;
        w_res.status = w_status;
        if (w_status == ST_OK) begin
            w_res.image_width  = r_width;
            w_res.image_height = r_height_abs;
            if ({27'd0, w_fin_bits} == 32'(BC_FULL)) begin
                w_res.channel_bits  = 4'd8;
                w_res.channel_count = 2'd3;
            end else begin
                w_res.channel_bits  = w_fin_bits[3:0];
                w_res.channel_count = 2'd1;
            end
            if (w_core) begin
                w_res.horiz_dpi = CORE_DPI_Q8;
                w_res.vert_dpi  = CORE_DPI_Q8;
            end else begin
                w_res.horiz_dpi = r_hdpi;
                w_res.vert_dpi  = r_vdpi;
            end
        end
    end

    // End-of-header quantities from the stored fields.
    assign w_hprod      = {11'd0, r_x_pels} * {32'd0, DPI_MUL};
    assign w_vprod      = {11'd0, r_y_pels} * {32'd0, DPI_MUL};
    assign w_pal_need   = {25'd0, r_hdr} + {24'd0, FILE_HDR_BYTES} +
                          (w_core ? 33'd3 : 33'd4);
    assign w_neg_height = 32'd0 - r_height;

    always_ff @(posedge i_clk) begin
        r_hdpi   <= w_hprod[42:8];
        r_vdpi   <= w_vprod[42:8];
        r_pal_ok <= ({1'b0, r_data_offset} >= w_pal_need);
        if (!r_height[31]) begin
            r_height_abs <= r_height[30:0];
        end else if (r_height == 32'h8000_0000) begin
            r_height_abs <= '1;
        end else begin
            r_height_abs <= w_neg_height[30:0];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_finished <= 1'b1;
        end else begin
            r_pos      <= n_pos;
            r_finished <= n_finished;
        end
    end

    // Field registers; a start beat clears them before use.
    always_ff @(posedge i_clk) begin
        r_shift       <= n_shift;
        r_data_offset <= n_data_offset;
        r_hdr         <= n_hdr;
        r_width       <= n_width;
        r_height      <= n_height;
        r_bit_count   <= n_bit_count;
        r_x_pels      <= n_x_pels;
        r_y_pels      <= n_y_pels;
    end

    bhp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_act & w_emit),
        .i_res       (w_res),
        .o_full      (w_buf_full),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> rtl/bhp_out_buf.sv
// ----------------------------------------------------------------------------
// BMP header parser result buffer
// Output register with one skid entry, so a new result can be taken while
// the previous one is still stalled downstream.
// ----------------------------------------------------------------------------
module bhp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  bhp_pkg::t_out_beat i_res,
    output logic              o_full,
    output logic              o_out_valid,
    output bhp_pkg::t_out_beat o_out_beat,
    input  logic              i_out_stall
);
    import bhp_pkg::*;

    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_beat r_out, n_out;
    t_out_beat r_skid, n_skid;
    logic      w_open;

    // The output register can load when it is empty or its beat leaves now.
    assign w_open = ~r_out_valid | ~i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_open) begin
            n_out_valid  = r_skid_valid | i_res_valid;
            n_out        = r_skid_valid ? r_skid : i_res;
            n_skid_valid = 1'b0;
        end else if (i_res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

>>> bench/tb_bmp_header_parser_top.sv
// ----------------------------------------------------------------------------
// BMP header parser testbench
// Streams whole BMP headers into the parser one byte beat at a time and
// checks every result beat against a cycle-free model of the header walk.
// Files are built from header parameters, so well-formed files reach the end
// of the DIB header while corrupted ones hit each early check.
// ----------------------------------------------------------------------------
module tb_bmp_header_parser_top;
    import bhp_pkg::*;

    logic       i_clk;
    logic       rst_n;
    logic       in_valid;
    t_in_beat   in_beat;
    logic       out_stall;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_beat  o_out_beat;

    // Scratch file image, large enough for the biggest DIB header.
    logic [7:0] img [0:139];
    int         img_len;

    // Parser state as the model tracks it.
    logic [7:0]  scan_pos;
    logic        scan_done;
    logic [31:0] byte_window;
    logic [31:0] seen_offset;
    logic [31:0] seen_hsize;
    logic [31:0] seen_width;
    logic [31:0] seen_height;
    logic [15:0] seen_planes;
    logic [15:0] seen_bitcnt;
    logic [31:0] seen_xpels;
    logic [31:0] seen_ypels;

    t_out_beat   expected_formats[$];

    logic        calm;
    int          fail_count;
    int          sent_bytes;
    int          files_sent;
    int          formats_ok;
    int          formats_rejected;
    int          beats_checked;

    bmp_header_parser_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_beat   (in_beat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (out_stall)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog.
    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    // Downstream back-pressure, switched off during calm stretches.
    always @(negedge i_clk) begin
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 32);
    end

    function automatic logic size_known(input logic [31:0] s);
        return s == HDR_CORE || s == HDR_INFO || s == HDR_INFO2 ||
               s == HDR_INFO4 || s == HDR_INFO5;
    endfunction

    function automatic logic bit_count_ok(input logic [15:0] bc);
        return bc == BC_ONE || bc == BC_FOUR || bc == BC_EIGHT || bc == BC_FULL;
    endfunction

    // Image format at the last header byte, or a dimension/palette error.
    function automatic t_out_beat header_summary();
        t_out_beat   r;
        logic        core;
        logic [31:0] h;
        logic        pal_ok;
        logic [63:0] psize;
        logic [63:0] xprod;
        logic [63:0] yprod;
        r = '0;
        core = (seen_hsize == HDR_CORE);
        psize = core ? 64'd3 : 64'd4;
        if (core || !seen_height[31]) begin
            h = seen_height;
        end else if (seen_height == 32'h8000_0000) begin
            h = 32'h7FFF_FFFF;
        end else begin
            h = 32'd0 - seen_height;
        end
        pal_ok = (seen_bitcnt == BC_FULL) ||
                 ({32'd0, seen_offset} >= {32'd0, seen_hsize} + 64'd14 + psize);
        if (seen_width == 32'd0 || h == 32'd0 || !pal_ok) begin
            r.status = ST_DIMS;
            return r;
        end
        r.status = ST_OK;
        r.image_width = seen_width;
        r.image_height = h[30:0];
        if (seen_bitcnt == BC_FULL) begin
            r.channel_bits = 4'd8;
            r.channel_count = 2'd3;
        end else begin
            r.channel_bits = seen_bitcnt[3:0];
            r.channel_count = 2'd1;
        end
        if (core) begin
            r.horiz_dpi = CORE_DPI_Q8;
            r.vert_dpi = CORE_DPI_Q8;
        end else begin
            xprod = ({32'd0, seen_xpels} * 64'd1665) >> 8;
            yprod = ({32'd0, seen_ypels} * 64'd1665) >> 8;
            r.horiz_dpi = xprod[34:0];
            r.vert_dpi = yprod[34:0];
        end
        return r;
    endfunction

    // Advance the header walk by one accepted byte and queue any result.
    task track_header_byte(input logic [7:0] b, input logic st);
        t_out_beat   res;
        t_status     stat;
        logic        emit;
        logic [7:0]  p;
        logic [31:0] w32;
        logic [15:0] w16;
        if (st) begin
            scan_pos = 8'd0;
            byte_window = '0;
            seen_offset = '0;
            seen_hsize = '0;
            seen_width = '0;
            seen_height = '0;
            seen_planes = '0;
            seen_bitcnt = '0;
            seen_xpels = '0;
            seen_ypels = '0;
            scan_done = 1'b0;
        end else if (scan_done) begin
            return;
        end
        res = '0;
        stat = ST_OK;
        emit = 1'b0;
        p = scan_pos;
        byte_window = {b, byte_window[31:8]};
        w32 = byte_window;
        w16 = byte_window[31:16];

        if (p == POS_SIG0 || p == POS_SIG1) begin
            if (b != ((p == POS_SIG0) ? SIG_FIRST : SIG_SECOND)) begin
                stat = ST_BAD_SIG;
                emit = 1'b1;
            end
        end else if (p == POS_RSVD_END) begin
            if (w32 != 32'd0) begin
                stat = ST_RESERVED;
                emit = 1'b1;
            end
        end else if (p == POS_OFFSET_END) begin
            seen_offset = w32;
        end else if (p == POS_HSIZE_END) begin
            seen_hsize = w32;
            if (!size_known(w32)) begin
                stat = ST_HDR_SIZE;
                emit = 1'b1;
            end
        end else if (p >= POS_DIB_FIELDS) begin
            if (seen_hsize == HDR_CORE) begin
                // Core header: 16-bit fields, ends at the bit count at the latest.
                if (p == CORE_POS_WIDTH) begin
                    seen_width = {16'd0, w16};
                end else if (p == CORE_POS_HEIGHT) begin
                    seen_height = {16'd0, w16};
                end else if (p == CORE_POS_PLANES) begin
                    seen_planes = w16;
                    if (w16 != 16'd1) begin
                        stat = ST_PLANES;
                        emit = 1'b1;
                    end
                end else if (p == CORE_POS_BITS) begin
                    seen_bitcnt = w16;
                    if (!bit_count_ok(w16)) stat = ST_BIT_COUNT;
                    emit = 1'b1;
                end
            end else begin
                // Info headers: 32-bit dimensions and resolutions.
                if (p == INFO_POS_WIDTH) begin
                    seen_width = w32;
                end else if (p == INFO_POS_HEIGHT) begin
                    seen_height = w32;
                end else if (p == INFO_POS_PLANES) begin
                    seen_planes = w16;
                    if (w16 != 16'd1) begin
                        stat = ST_PLANES;
                        emit = 1'b1;
                    end
                end else if (p == INFO_POS_BITS) begin
                    seen_bitcnt = w16;
                    if (!bit_count_ok(w16)) begin
                        stat = ST_BIT_COUNT;
                        emit = 1'b1;
                    end
                end else if (p == INFO_POS_XPELS) begin
                    seen_xpels = w32;
                end else if (p == INFO_POS_YPELS) begin
                    seen_ypels = w32;
                end
                if (!emit && {24'd0, p} == seen_hsize + 32'd13) emit = 1'b1;
            end
            if (emit && stat == ST_OK) begin
                res = header_summary();
                stat = res.status;
            end
        end

        if (p != POS_LAST) scan_pos = p + 8'd1;

        if (emit) begin
            scan_done = 1'b1;
            if (stat != ST_OK) res = '0;
            res.status = stat;
            if (stat == ST_OK) formats_ok++;
            else formats_rejected++;
            expected_formats.push_back(res);
        end
    endtask

    function void check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result beat with the oldest expected format.
    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (rst_n && o_out_valid && !out_stall) begin
            beats_checked++;
            if (expected_formats.size() == 0) begin
                $error("result beat with status %0d arrived with none expected",
                       o_out_beat.status);
                fail_count++;
            end else begin
                want = expected_formats.pop_front();
                check_field("status", want.status, o_out_beat.status);
                check_field("image_width", want.image_width, o_out_beat.image_width);
                check_field("image_height", want.image_height, o_out_beat.image_height);
                check_field("channel_bits", want.channel_bits,
                            o_out_beat.channel_bits);
                check_field("channel_count", want.channel_count,
                            o_out_beat.channel_count);
                check_field("horiz_dpi", want.horiz_dpi, o_out_beat.horiz_dpi);
                check_field("vert_dpi", want.vert_dpi, o_out_beat.vert_dpi);
            end
        end
    end

    // Send one byte beat, with an occasional idle gap ahead of it.
    task send_byte(input logic [7:0] b, input logic st);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 32) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            in_beat <= '{data_byte: 8'($urandom), start_req: 1'($urandom)};
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat <= '{data_byte: b, start_req: st};
        do @(posedge i_clk); while (o_in_stall);
        sent_bytes++;
        track_header_byte(b, st);
    endtask

    task put_le(input int at, input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) img[at + i] = v[8 * i +: 8];
    endtask

    // Lay out a file and DIB header; unused bytes keep random content.
    task build_header(input logic [31:0] hs, input logic [31:0] w, input logic [31:0] h,
                      input logic [15:0] pl, input logic [15:0] bc,
                      input logic [31:0] xp, input logic [31:0] yp,
                      input logic [31:0] off);
        for (int i = 0; i < 140; i++) img[i] = 8'($urandom);
        img[0] = SIG_FIRST;
        img[1] = SIG_SECOND;
        put_le(6, 32'd0, 4);
        put_le(10, off, 4);
        put_le(14, hs, 4);
        if (hs == HDR_CORE) begin
            put_le(18, w, 2);
            put_le(20, h, 2);
            put_le(22, {16'd0, pl}, 2);
            put_le(24, {16'd0, bc}, 2);
        end else begin
            put_le(18, w, 4);
            put_le(22, h, 4);
            put_le(26, {16'd0, pl}, 2);
            put_le(28, {16'd0, bc}, 2);
            put_le(38, xp, 4);
            put_le(42, yp, 4);
        end
        img_len = 14 + (size_known(hs) ? int'(hs) : 12);
    endtask

    // Send the first count bytes of the image, then some trailing junk.
    task send_file(input int count, input int tail);
        for (int i = 0; i < count; i++) send_byte(img[i], i == 0);
        for (int i = 0; i < tail; i++) send_byte(8'($urandom), 1'b0);
        files_sent++;
    endtask

    // Bytes before any start, a restart mid-file, and bytes after a result.
    task test_stream_framing();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(SIG_FIRST, 1'b0);
        build_header(HDR_CORE, 32'd640, 32'd480, 16'd1, BC_FULL, 0, 0, 32'd26);
        send_file(10, 0);
        send_file(img_len, 4);
    endtask

    // Well-formed headers of every size and pixel format, with field extremes.
    task test_valid_headers();
        build_header(HDR_CORE, 32'hFFFF, 32'hFFFF, 16'd1, BC_FULL, 0, 0, 32'd26);
        send_file(img_len, 0);
        build_header(HDR_INFO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, BC_EIGHT,
                     32'hFFFF_FFFF, 32'd0, 32'd58);
        send_file(img_len, 0);
        build_header(HDR_INFO2, 32'h8000_0000, 32'd1, 16'd1, BC_ONE,
                     32'd2835, 32'd3780, 32'h7FFF_FFFF);
        send_file(img_len, 0);
        build_header(HDR_INFO4, 32'd1, 32'hFFFF_F000, 16'd1, BC_FOUR,
                     32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_file(img_len, 0);
        build_header(HDR_INFO5, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1, BC_FULL,
                     32'd11811, 32'd11811, 32'd0);
        send_file(img_len, 2);
    endtask

    // Signature, reserved word, header size, planes and bit count errors.
    task test_header_checks();
        build_header(HDR_CORE, 32'd8, 32'd8, 16'd1, BC_FULL, 0, 0, 32'd26);
        img[0] = 8'h43;
        send_file(img_len, 0);
        build_header(HDR_CORE, 32'd8, 32'd8, 16'd1, BC_FULL, 0, 0, 32'd26);
        img[1] = 8'hCD;
        send_file(img_len, 0);
        build_header(HDR_INFO, 32'd8, 32'd8, 16'd1, BC_FULL, 0, 0, 32'd54);
        img[9] = 8'h80;
        send_file(img_len, 0);
        build_header(32'd0, 32'd8, 32'd8, 16'd1, BC_FULL, 0, 0, 32'd54);
        send_file(img_len, 0);
        build_header(32'hFFFF_FFFF, 32'd8, 32'd8, 16'd1, BC_FULL, 0, 0, 32'd54);
        send_file(img_len, 0);
        build_header(HDR_CORE, 32'd8, 32'd8, 16'd0, BC_FULL, 0, 0, 32'd26);
        send_file(img_len, 0);
        build_header(HDR_INFO, 32'd8, 32'd8, 16'hFFFF, BC_FULL, 0, 0, 32'd54);
        send_file(img_len, 0);
        build_header(HDR_CORE, 32'd8, 32'd8, 16'd1, 16'd16, 0, 0, 32'd26);
        send_file(img_len, 0);
        build_header(HDR_INFO, 32'd8, 32'd8, 16'd1, 16'd32, 0, 0, 32'd54);
        send_file(img_len, 0);
    endtask

    // Zero dimensions and the palette size boundary for both header kinds.
    task test_dims_and_palette();
        build_header(HDR_CORE, 32'd0, 32'd5, 16'd1, BC_FULL, 0, 0, 32'd26);
        send_file(img_len, 0);
        build_header(HDR_INFO, 32'd5, 32'd0, 16'd1, BC_FULL, 0, 0, 32'd54);
        send_file(img_len, 0);
        build_header(HDR_CORE, 32'd5, 32'd5, 16'd1, BC_EIGHT, 0, 0, 32'd28);
        send_file(img_len, 0);
        build_header(HDR_CORE, 32'd5, 32'd5, 16'd1, BC_EIGHT, 0, 0, 32'd29);
        send_file(img_len, 0);
        build_header(HDR_INFO, 32'd5, 32'd5, 16'd1, BC_ONE, 32'd100, 32'd100, 32'd57);
        send_file(img_len, 0);
        build_header(HDR_INFO, 32'd5, 32'd5, 16'd1, BC_FOUR, 32'd100, 32'd100, 32'd58);
        send_file(img_len, 0);
    endtask

    // Mostly well-formed files with random content, plus corrupted,
    // truncated and junk-trailed ones.
    task test_random_files();
        int          base;
        int          r;
        logic [31:0] hs;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] off;
        logic [31:0] need;
        logic [15:0] pl;
        logic [15:0] bc;
        base = sent_bytes;
        while (sent_bytes < 1500) begin
            calm = (sent_bytes - base < 150);

            r = $urandom_range(0, 99);
            if (r < 45) hs = HDR_CORE;
            else if (r < 70) hs = HDR_INFO;
            else if (r < 80) hs = HDR_INFO2;
            else if (r < 88) hs = HDR_INFO4;
            else if (r < 95) hs = HDR_INFO5;
            else hs = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 130);

            if ($urandom_range(0, 99) < 90) begin
                case ($urandom_range(0, 3))
                    0: bc = BC_ONE;
                    1: bc = BC_FOUR;
                    2: bc = BC_EIGHT;
                    default: bc = BC_FULL;
                endcase
            end else begin
                bc = 16'($urandom);
            end
            pl = ($urandom_range(0, 99) < 94) ? 16'd1 : 16'($urandom);

            r = $urandom_range(0, 99);
            if (r < 5) w = 32'd0;
            else if (r < 35) w = $urandom_range(1, 4096);
            else w = $urandom;

            r = $urandom_range(0, 99);
            if (r < 5) h = 32'd0;
            else if (r < 10) h = 32'h8000_0000;
            else if (r < 40) h = $urandom_range(1, 4096);
            else if (r < 55) h = 32'd0 - 32'($urandom_range(1, 4096));
            else h = $urandom;

            // Data offset around the smallest palette that passes.
            need = hs + 32'd14 + ((hs == HDR_CORE) ? 32'd3 : 32'd4);
            r = $urandom_range(0, 99);
            if (r < 50) off = need + $urandom_range(0, 64);
            else if (r < 80) off = need - $urandom_range(1, 3);
            else off = $urandom;

            build_header(hs, w, h, pl, bc, $urandom, $urandom, off);

            r = $urandom_range(0, 99);
            if (r < 4) img[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            else if (r < 8) img[$urandom_range(6, 9)] = 8'($urandom_range(1, 255));

            r = $urandom_range(0, 99);
            if (r < 8) send_file($urandom_range(1, img_len - 1), 0);
            else if (r < 23) send_file(img_len, $urandom_range(1, 6));
            else send_file(img_len, 0);
        end
        calm = 1'b0;
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_beat = '0;
        out_stall = 1'b0;
        calm = 1'b0;
        fail_count = 0;
        sent_bytes = 0;
        files_sent = 0;
        formats_ok = 0;
        formats_rejected = 0;
        beats_checked = 0;
        scan_pos = 8'd0;
        scan_done = 1'b1;
        byte_window = '0;
        seen_offset = '0;
        seen_hsize = '0;
        seen_width = '0;
        seen_height = '0;
        seen_planes = '0;
        seen_bitcnt = '0;
        seen_xpels = '0;
        seen_ypels = '0;

        repeat (4) @(negedge i_clk);
        rst_n <= 1'b1;

        test_stream_framing();
        test_valid_headers();
        test_header_checks();
        test_dims_and_palette();
        test_random_files();

        @(negedge i_clk);
        in_valid <= 1'b0;

        // Drain the outstanding results, then allow for the output register.
        while (expected_formats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d files in %0d byte beats; checked %0d result beats.",
                 files_sent, sent_bytes, beats_checked);
        $display("Headers accepted: %0d, rejected with an error status: %0d.",
                 formats_ok, formats_rejected);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
